/* design/m3i_pkg.sv */
// ---------------------------------------------------------------------------
// m3i_pkg
// Shared types and constants for the 3x3 matrix inverse pipeline.
// ---------------------------------------------------------------------------
package m3i_pkg;

  // element, product, cofactor and determinant widths
  typedef logic signed [15:0] elem_t;
  typedef logic signed [31:0] prod_t;
  typedef logic signed [32:0] cof_t;
  typedef logic signed [48:0] dprod_t;
  typedef logic signed [49:0] det_t;
  typedef logic signed [31:0] inv_t;

  // quotient bits produced by the divider (2x the rounded result)
  localparam int DIV_BITS = 33;
  // register stages of the cofactor/determinant unit
  localparam int COF_LAT  = 4;
  // register stages of one divider lane (operand prep plus one per bit)
  localparam int LANE_LAT = DIV_BITS + 1;

  typedef struct packed {
    elem_t in_r0c0;
    elem_t in_r0c1;
    elem_t in_r0c2;
    elem_t in_r1c0;
    elem_t in_r1c1;
    elem_t in_r1c2;
    elem_t in_r2c0;
    elem_t in_r2c1;
    elem_t in_r2c2;
  } in_word_t;

  typedef struct packed {
    inv_t inv_r0c0;
    inv_t inv_r0c1;
    inv_t inv_r0c2;
    inv_t inv_r1c0;
    inv_t inv_r1c1;
    inv_t inv_r1c2;
    inv_t inv_r2c0;
    inv_t inv_r2c1;
    inv_t inv_r2c2;
    logic singular;
  } out_word_t;

endpackage

/* design/m3i_cofactor.sv */
// ---------------------------------------------------------------------------
// m3i_cofactor
// Four-stage pipeline forming the nine exact cofactors and the determinant.
// ---------------------------------------------------------------------------
module m3i_cofactor (
  input  logic           clk,
  input  logic           en,
  input  m3i_pkg::elem_t m_i   [3][3],
  output m3i_pkg::cof_t  cof_o [3][3],
  output m3i_pkg::det_t  det_o
);

  m3i_pkg::prod_t  pa_r  [3][3];
  m3i_pkg::prod_t  pb_r  [3][3];
  m3i_pkg::elem_t  row1_r [3];
  m3i_pkg::elem_t  row2_r [3];
  m3i_pkg::cof_t   cof2_r [3][3];
  m3i_pkg::cof_t   cof3_r [3][3];
  m3i_pkg::cof_t   cof4_r [3][3];
  m3i_pkg::dprod_t dp_r  [3];
  m3i_pkg::det_t   det_r;

  // stage 1: the two minor products of every cofactor
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pa_r[r][c] <= m_i[(r+1)%3][(c+1)%3] * m_i[(r+2)%3][(c+2)%3];
          pb_r[r][c] <= m_i[(r+1)%3][(c+2)%3] * m_i[(r+2)%3][(c+1)%3];
        end
        row1_r[r] <= m_i[0][r];
      end
    end
  end

  // stage 2: cofactor differences
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          cof2_r[r][c] <= m3i_pkg::cof_t'(pa_r[r][c]) - m3i_pkg::cof_t'(pb_r[r][c]);
        end
        row2_r[r] <= row1_r[r];
      end
    end
  end

  // stage 3: expand along row 0
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        dp_r[c] <= row2_r[c] * cof2_r[0][c];
      end
      cof3_r <= cof2_r;
    end
  end

  // stage 4: sum the row expansion
  always_ff @(posedge clk) begin
    if (en) begin
      det_r  <= m3i_pkg::det_t'(dp_r[0]) + m3i_pkg::det_t'(dp_r[1])
              + m3i_pkg::det_t'(dp_r[2]);
      cof4_r <= cof3_r;
    end
  end

  assign cof_o = cof4_r;
  assign det_o = det_r;

endmodule

/* design/m3i_div_lane.sv */
// ---------------------------------------------------------------------------
// m3i_div_lane
// One divider lane: rounded, saturated cofactor * 2^28 / determinant,
// pipelined restoring division producing one quotient bit per stage.
// ---------------------------------------------------------------------------
module m3i_div_lane (
  input  logic          clk,
  input  logic          en,
  input  m3i_pkg::cof_t cof_i,
  input  m3i_pkg::det_t det_i,
  output m3i_pkg::inv_t inv_o
);

  localparam int NB = m3i_pkg::DIV_BITS;

  logic [60:0]   rem_r [NB+1];
  logic [NB-1:0] q_r   [NB+1];
  logic [49:0]   ud_r  [NB+1];
  logic          neg_r [NB+1];
  logic          ovf_r [NB+1];

  m3i_pkg::cof_t cof_abs;
  m3i_pkg::det_t det_abs;
  logic [60:0]   num;
  logic [83:0]   num_ext;
  logic [83:0]   den_top;
  logic [33:0]   q_inc;
  logic [31:0]   q_rnd;
  logic          sat;

  // prep: magnitudes, sign and overflow of the top quotient bit
  always_comb begin
    cof_abs = cof_i[32] ? -cof_i : cof_i;
    det_abs = det_i[49] ? -det_i : det_i;
    num     = {cof_abs[31:0], 29'b0};
    num_ext = {23'b0, num};
    den_top = {1'b0, det_abs, 33'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      q_r[0]   <= '0;
      ud_r[0]  <= det_abs;
      neg_r[0] <= cof_i[32] ^ det_i[49];
      ovf_r[0] <= (num_ext >= den_top);
    end
  end

  // one quotient bit per stage, from the top down
  for (genvar i = 0; i < NB; i++) begin : g_bit
    localparam int K = NB - 1 - i;
    logic [83:0] den_k;
    logic [83:0] rem_k;
    logic        take;

    always_comb begin
      den_k = {34'b0, ud_r[i]} << K;
      rem_k = {23'b0, rem_r[i]};
      take  = (rem_k >= den_k);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= take ? (rem_r[i] - den_k[60:0]) : rem_r[i];
        q_r[i+1]   <= q_r[i] | (take ? (NB'(1) << K) : '0);
        ud_r[i+1]  <= ud_r[i];
        neg_r[i+1] <= neg_r[i];
        ovf_r[i+1] <= ovf_r[i];
      end
    end
  end

  // round half away from zero and saturate
  always_comb begin
    q_inc = {1'b0, q_r[NB]} + 34'd1;
    q_rnd = q_inc[32:1];
    sat   = ovf_r[NB] || q_r[NB][32] || (q_r[NB][31:0] == '1);
    if (sat) begin
      inv_o = neg_r[NB] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (neg_r[NB]) begin
      inv_o = -$signed(q_rnd);
    end else begin
      inv_o = $signed(q_rnd);
    end
  end

endmodule

/* design/matrix3_inverse_top.sv */
// ---------------------------------------------------------------------------
// matrix3_inverse_top
// 3x3 matrix inverse by the adjugate, Q3.12 in, saturated Q15.16 out.
// ---------------------------------------------------------------------------
// Usage:
//   Present one matrix per word on in_data with in_valid; it is taken at a
//   rising edge where in_valid is high and in_stall is low. The inverse
//   leaves on out_data with out_valid, taken when out_stall is low.
//   A zero determinant sets singular and zeroes all nine elements.
// Throughput: one matrix per cycle while out_stall stays low.
// Depth: 4 cofactor and determinant stages, 34 divider stages and 1
//   output register lie between acceptance and out_valid. The
//   divider lanes, one restoring step per stage, set the depth.
// Stall: the whole pipeline freezes while a result waits on out_stall;
//   in_stall then rises in the same cycle.
// Reset: rst_n low for one clock empties the pipeline; payload registers
//   are not cleared.
// ---------------------------------------------------------------------------
module matrix3_inverse_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  m3i_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output m3i_pkg::out_word_t out_data
);

  localparam int PIPE = m3i_pkg::COF_LAT + m3i_pkg::LANE_LAT;

  logic                 en;
  logic [PIPE-1:0]      vld_r;
  logic [m3i_pkg::LANE_LAT-1:0] sing_r;
  logic                 out_valid_r;
  m3i_pkg::out_word_t   out_data_r;
  m3i_pkg::elem_t       m   [3][3];
  m3i_pkg::cof_t        cof [3][3];
  m3i_pkg::det_t        det;
  m3i_pkg::inv_t        inv [3][3];

  // advance unless a finished word is held by the receiver
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  assign m[0][0] = in_data.in_r0c0;
  assign m[0][1] = in_data.in_r0c1;
  assign m[0][2] = in_data.in_r0c2;
  assign m[1][0] = in_data.in_r1c0;
  assign m[1][1] = in_data.in_r1c1;
  assign m[1][2] = in_data.in_r1c2;
  assign m[2][0] = in_data.in_r2c0;
  assign m[2][1] = in_data.in_r2c1;
  assign m[2][2] = in_data.in_r2c2;

  m3i_cofactor u_cof (
    .clk   (clk),
    .en    (en),
    .m_i   (m),
    .cof_o (cof),
    .det_o (det)
  );

  // nine divider lanes, inverse element (r,c) takes cofactor (c,r)
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      m3i_div_lane u_lane (
        .clk   (clk),
        .en    (en),
        .cof_i (cof[c][r]),
        .det_i (det),
        .inv_o (inv[r][c])
      );
    end
  end

  // track valid words through the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[PIPE-2:0], in_valid};
      out_valid_r <= vld_r[PIPE-1];
    end
  end

  // carry the singular flag alongside the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      sing_r <= {sing_r[m3i_pkg::LANE_LAT-2:0], (det == '0)};
    end
  end

  // merge lane results into the output word
  always_ff @(posedge clk) begin
    if (en) begin
      if (sing_r[m3i_pkg::LANE_LAT-1]) begin
        out_data_r.inv_r0c0 <= '0;
        out_data_r.inv_r0c1 <= '0;
        out_data_r.inv_r0c2 <= '0;
        out_data_r.inv_r1c0 <= '0;
        out_data_r.inv_r1c1 <= '0;
        out_data_r.inv_r1c2 <= '0;
        out_data_r.inv_r2c0 <= '0;
        out_data_r.inv_r2c1 <= '0;
        out_data_r.inv_r2c2 <= '0;
        out_data_r.singular <= 1'b1;
      end else begin
        out_data_r.inv_r0c0 <= inv[0][0];
        out_data_r.inv_r0c1 <= inv[0][1];
        out_data_r.inv_r0c2 <= inv[0][2];
        out_data_r.inv_r1c0 <= inv[1][0];
        out_data_r.inv_r1c1 <= inv[1][1];
        out_data_r.inv_r1c2 <= inv[1][2];
        out_data_r.inv_r2c0 <= inv[2][0];
        out_data_r.inv_r2c1 <= inv[2][1];
        out_data_r.inv_r2c2 <= inv[2][2];
        out_data_r.singular <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
